// File: design/sdasc_pkg.sv
// ----------------------------------------------------------------------------
// sdasc_pkg
// Shared types and constants for the signed 16-bit to decimal ASCII unit.
// ----------------------------------------------------------------------------
package sdasc_pkg;

  localparam int VALUE_W    = 16;
  localparam int DIGIT_W    = 4;
  localparam int NUM_DIGITS = 5;
  localparam int CHAR_W     = 8;
  localparam int LEN_W      = 3;

  // One divide-by-ten stage per decimal digit
  localparam int DIV_STAGES = NUM_DIGITS;

  // floor(x / 10) == (x * 52429) >> 19 for every x below 43699
  localparam int               RECIP_W     = 17;
  localparam logic [RECIP_W-1:0] RECIP10   = 17'd52429;
  localparam int               RECIP_SHIFT = 19;
  localparam int               PROD_W      = VALUE_W + RECIP_W;

  localparam logic [CHAR_W-1:0] ASCII_ZERO  = 8'h30;
  localparam logic [CHAR_W-1:0] ASCII_MINUS = 8'h2D;
  localparam logic [CHAR_W-1:0] CHAR_ERROR  = 8'h00;

  localparam logic [LEN_W-1:0] MAX_LEN_RESET = 3'd6;

  typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] digits_t;

  // Work item carried down the conversion pipeline
  typedef struct packed {
    logic                neg;
    logic [VALUE_W-1:0]  quo;
    digits_t             digs;
  } conv_t;

endpackage

// File: design/signed_int16_to_decimal_ascii_unit.sv
// ----------------------------------------------------------------------------
// signed_int16_to_decimal_ascii_unit
// Converts signed 16-bit values into decimal ASCII text streams.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one signed 16-bit value per transaction on in_tdata.
//   out_* : one character per transaction, most significant first; a minus
//           sign leads negative values, no leading zeros, no terminator.
//           out_tlast marks the final character, which also carries the
//           text length. out_tuser high flags a text longer than max_length:
//           a single transaction with character 0 and length 0.
//   cfg_* : writes max_length (reset value 6); write only while idle.
// Timing:
//   An absolute-value stage, five divide-by-ten stages (one multiplier
//   each), a serializer load and the output register lie between input
//   and the first character. The serializer emits one character per cycle
//   while out_tready is high, so a value occupies it for 1 to 6 characters
//   (its text length, or one on error); the pipeline ahead buffers values.
// Reset and stall:
//   rst_n clears all valid bits and restores max_length. When out_tready
//   is low, every stage holds its data and in_tready drops once the
//   pipeline is full; nothing is lost or repeated.
// ----------------------------------------------------------------------------
module signed_int16_to_decimal_ascii_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,   // [15:0] value
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata,  // [7:0] character, [10:8] text_length, rest 0
  output logic        out_tlast,
  output logic        out_tuser,  // [0] too_long
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data    // [2:0] max_length
);
  import sdasc_pkg::*;

  logic [LEN_W-1:0] max_length_r;

  logic             st_valid [DIV_STAGES+1];
  logic             st_ready [DIV_STAGES+1];
  conv_t            st_data  [DIV_STAGES+1];

  logic              s0_valid_r;
  conv_t             s0_r;
  conv_t             s0_nxt;
  logic [CHAR_W-1:0] ch;
  logic [LEN_W-1:0]  len;

  // configuration
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_length_r <= MAX_LEN_RESET;
    end else if (cfg_valid && cfg_ready) begin
      max_length_r <= cfg_data;
    end
  end

  // sign and magnitude stage
  always_comb begin
    s0_nxt.neg  = in_tdata[VALUE_W-1];
    s0_nxt.quo  = in_tdata[VALUE_W-1] ? VALUE_W'(16'd0 - in_tdata) : in_tdata;
    s0_nxt.digs = '0;
  end

  assign in_tready = !s0_valid_r || st_ready[0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s0_valid_r <= 1'b0;
    end else if (in_tready) begin
      s0_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      s0_r <= s0_nxt;
    end
  end

  assign st_valid[0] = s0_valid_r;
  assign st_data[0]  = s0_r;

  for (genvar g = 0; g < DIV_STAGES; g++) begin : g_div
    sdasc_div_stage u_div (
      .clk       (clk),
      .rst_n     (rst_n),
      .in_valid  (st_valid[g]),
      .in_ready  (st_ready[g]),
      .in_data   (st_data[g]),
      .out_valid (st_valid[g+1]),
      .out_ready (st_ready[g+1]),
      .out_data  (st_data[g+1])
    );
  end

  sdasc_serializer u_ser (
    .clk        (clk),
    .rst_n      (rst_n),
    .max_length (max_length_r),
    .in_valid   (st_valid[DIV_STAGES]),
    .in_ready   (st_ready[DIV_STAGES]),
    .in_data    (st_data[DIV_STAGES]),
    .out_valid  (out_tvalid),
    .out_ready  (out_tready),
    .out_char   (ch),
    .out_last   (out_tlast),
    .out_len    (len),
    .out_err    (out_tuser)
  );

  assign out_tdata = {5'd0, len, ch};

endmodule

// File: design/sdasc_div_stage.sv
// ----------------------------------------------------------------------------
// sdasc_div_stage
// One pipeline stage: divide the running quotient by ten and shift the
// remainder into the digit vector.
// ----------------------------------------------------------------------------
module sdasc_div_stage (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_ready,
  input  sdasc_pkg::conv_t in_data,
  output logic            out_valid,
  input  logic            out_ready,
  output sdasc_pkg::conv_t out_data
);
  import sdasc_pkg::*;

  logic               valid_r;
  conv_t              data_r;
  conv_t              data_nxt;
  logic [PROD_W-1:0]  prod;
  logic [VALUE_W-1:0] quo;
  logic [VALUE_W-1:0] quo_x10;
  logic [DIGIT_W-1:0] rem;

  always_comb begin
    prod     = PROD_W'(in_data.quo) * PROD_W'(RECIP10);
    quo      = VALUE_W'(prod >> RECIP_SHIFT);
    quo_x10  = (quo << 3) + (quo << 1);
    rem      = DIGIT_W'(in_data.quo - quo_x10);
    data_nxt.neg  = in_data.neg;
    data_nxt.quo  = quo;
    // newest remainder goes to the low end; the most significant digit
    // ends up at index 0
    data_nxt.digs = {in_data.digs[NUM_DIGITS-2:0], rem};
  end

  assign in_ready  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= data_nxt;
    end
  end

endmodule

// File: design/sdasc_serializer.sv
// ----------------------------------------------------------------------------
// sdasc_serializer
// Turns one converted value into its run of characters, one per cycle
// while out_ready allows, through a registered output stage.
// ----------------------------------------------------------------------------
module sdasc_serializer (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic [sdasc_pkg::LEN_W-1:0] max_length,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  sdasc_pkg::conv_t            in_data,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [sdasc_pkg::CHAR_W-1:0] out_char,
  output logic                        out_last,
  output logic [sdasc_pkg::LEN_W-1:0] out_len,
  output logic                        out_err
);
  import sdasc_pkg::*;

  // held item
  logic             hold_r,     hold_nxt;
  logic             err_r,      err_nxt;
  logic             negp_r,     negp_nxt;
  logic [LEN_W-1:0] rem_r,      rem_nxt;
  logic [LEN_W-1:0] total_r,    total_nxt;
  digits_t          dq_r,       dq_nxt;

  // output register
  logic              ov_r,      ov_nxt;
  logic [CHAR_W-1:0] och_r,     och_nxt;
  logic              olast_r,   olast_nxt;
  logic [LEN_W-1:0]  olen_r,    olen_nxt;
  logic              oerr_r,    oerr_nxt;

  logic             out_free;
  logic             emit;
  logic             emit_last;
  logic             load;
  logic [LEN_W-1:0] ndig;
  logic [LEN_W-1:0] ld_total;
  digits_t          aligned;

  // count significant digits and left-align them at index 0
  always_comb begin
    priority if (in_data.digs[0] != '0) begin
      ndig    = 3'd5;
      aligned = in_data.digs;
    end else if (in_data.digs[1] != '0) begin
      ndig    = 3'd4;
      aligned = in_data.digs >> DIGIT_W;
    end else if (in_data.digs[2] != '0) begin
      ndig    = 3'd3;
      aligned = in_data.digs >> (2 * DIGIT_W);
    end else if (in_data.digs[3] != '0) begin
      ndig    = 3'd2;
      aligned = in_data.digs >> (3 * DIGIT_W);
    end else begin
      ndig    = 3'd1;
      aligned = in_data.digs >> (4 * DIGIT_W);
    end
    ld_total = ndig + LEN_W'(in_data.neg);
  end

  assign out_free  = !ov_r || out_ready;
  assign emit      = hold_r && out_free;
  assign emit_last = err_r || (!negp_r && (rem_r == 3'd1));
  assign in_ready  = !hold_r || (emit && emit_last);
  assign load      = in_valid && in_ready;

  always_comb begin
    hold_nxt  = hold_r;
    err_nxt   = err_r;
    negp_nxt  = negp_r;
    rem_nxt   = rem_r;
    total_nxt = total_r;
    dq_nxt    = dq_r;
    ov_nxt    = ov_r && !out_ready;
    och_nxt   = och_r;
    olast_nxt = olast_r;
    olen_nxt  = olen_r;
    oerr_nxt  = oerr_r;

    if (emit) begin
      ov_nxt = 1'b1;
      if (err_r) begin
        och_nxt   = CHAR_ERROR;
        olast_nxt = 1'b1;
        olen_nxt  = '0;
        oerr_nxt  = 1'b1;
        hold_nxt  = 1'b0;
      end else if (negp_r) begin
        och_nxt   = ASCII_MINUS;
        olast_nxt = 1'b0;
        olen_nxt  = '0;
        oerr_nxt  = 1'b0;
        negp_nxt  = 1'b0;
      end else begin
        och_nxt   = ASCII_ZERO + CHAR_W'(dq_r[0]);
        olast_nxt = emit_last;
        olen_nxt  = emit_last ? total_r : '0;
        oerr_nxt  = 1'b0;
        rem_nxt   = rem_r - 3'd1;
        dq_nxt    = dq_r >> DIGIT_W;
        if (emit_last) begin
          hold_nxt = 1'b0;
        end
      end
    end

    if (load) begin
      hold_nxt  = 1'b1;
      err_nxt   = ld_total > max_length;
      negp_nxt  = in_data.neg;
      rem_nxt   = ndig;
      total_nxt = ld_total;
      dq_nxt    = aligned;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hold_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      hold_r <= hold_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    err_r   <= err_nxt;
    negp_r  <= negp_nxt;
    rem_r   <= rem_nxt;
    total_r <= total_nxt;
    dq_r    <= dq_nxt;
    och_r   <= och_nxt;
    olast_r <= olast_nxt;
    olen_r  <= olen_nxt;
    oerr_r  <= oerr_nxt;
  end

  assign out_valid = ov_r;
  assign out_char  = och_r;
  assign out_last  = olast_r;
  assign out_len   = olen_r;
  assign out_err   = oerr_r;

endmodule
